// ===== src/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rfa_pkg.sv =====
// shared types and constants for the rational fraction alu
package rfa_pkg;
  localparam int OperandWidth = 32;
  localparam int MagWidth = 64;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_CMP = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_GCD_START,
    CMD_GCD_STEP,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_MUL,
    CMD_APPLY,
    CMD_FINISH
  } cmd_op_t;

  typedef enum logic [3:0] {
    SEL_RED_A,
    SEL_RED_B,
    SEL_LCM,
    SEL_SCALE,
    SEL_MUL,
    SEL_RED_R,
    SEL_CMP
  } sel_t;

  typedef struct packed {
    cmd_op_t op;
    sel_t    sel;
    logic    part;
  } rfa_cmd_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic op_err;
    logic num_zero;
  } rfa_status_t;
endpackage

// ===== src/rfa_datapath.sv =====
// datapath: operand registers, shared gcd, divider and multiplier
module rfa_datapath (
  input  logic                clk,
  input  rfa_pkg::rfa_cmd_t   cmd,
  input  logic [2:0]          func,
  input  logic [31:0]         a_num,
  input  logic [31:0]         a_den,
  input  logic [31:0]         b_num,
  input  logic [31:0]         b_den,
  output rfa_pkg::rfa_status_t stat,
  output logic [63:0]         res_num,
  output logic [62:0]         res_den,
  output logic                is_greater,
  output logic                is_less,
  output logic                is_equal,
  output logic                status
);
  import rfa_pkg::*;

  logic [2:0]  fn;
  logic        an_s, bn_s, sign_r, s2;
  logic [63:0] an, ad, bn, bd, rn, rd;
  logic [63:0] gx, gy;
  logic [6:0]  gk;
  logic [63:0] dq, drem, ddiv;
  logic [6:0]  dcnt;
  logic [63:0] g_save, t1;
  logic        err;
  logic [31:0] m_x, m_y;
  logic [63:0] m_p;

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? (~v + 32'd1) : v;
  endfunction

  assign stat.gcd_done = (gy == 64'd0);
  assign stat.div_done = (dcnt == 7'd0);
  assign stat.op_err = err;
  assign stat.num_zero = (rn == 64'd0);

  logic [64:0] dtrial;
  assign dtrial = {drem[63:0], dq[63]} - {1'b0, ddiv};

  always_comb begin
    m_x = 32'd0;
    m_y = 32'd0;
    case (cmd.sel)
      SEL_SCALE: begin
        m_x = cmd.part ? bn[31:0] : an[31:0];
        m_y = cmd.part ? ad[31:0] : bd[31:0];
      end
      SEL_LCM: begin
        m_x = dq[31:0];
        m_y = bd[31:0];
      end
      SEL_MUL: begin
        m_x = cmd.part ? ad[31:0] : an[31:0];
        m_y = cmd.part ? ((fn == FUNC_DIV) ? bn[31:0] : bd[31:0])
                       : ((fn == FUNC_DIV) ? bd[31:0] : bn[31:0]);
      end
      SEL_CMP: begin
        m_x = cmd.part ? bn[31:0] : an[31:0];
        m_y = cmd.part ? ad[31:0] : bd[31:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    m_p <= 64'(m_x) * 64'(m_y);
    case (cmd.op)
      CMD_LOAD: begin
        fn <= func;
        an <= 64'(mag(a_num));
        ad <= 64'(mag(a_den));
        bn <= 64'(mag(b_num));
        bd <= 64'(mag(b_den));
        an_s <= a_num[31] ^ a_den[31];
        bn_s <= b_num[31] ^ b_den[31];
        err <= (a_den == 32'd0) || (b_den == 32'd0) ||
               ((func == 3'(FUNC_DIV)) && (b_num == 32'd0));
        is_greater <= 1'b0;
        is_less <= 1'b0;
        is_equal <= 1'b0;
      end
      CMD_GCD_START: begin
        gk <= 7'd0;
        case (cmd.sel)
          SEL_RED_A: begin gx <= an; gy <= ad; end
          SEL_RED_B: begin gx <= bn; gy <= bd; end
          SEL_LCM:   begin gx <= ad; gy <= bd; end
          default:   begin gx <= rn; gy <= rd; end
        endcase
      end
      CMD_GCD_STEP: begin
        if (gx == 64'd0) begin
          gx <= gy;
          gy <= 64'd0;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          gk <= gk + 7'd1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (gx >= gy) begin
          gx <= (gx - gy) >> 1;
        end else begin
          gy <= (gy - gx) >> 1;
        end
        if (gy == 64'd0) g_save <= gx << gk;
      end
      CMD_DIV_START: begin
        dcnt <= 7'd64;
        drem <= 64'd0;
        ddiv <= g_save;
        case (cmd.sel)
          SEL_RED_A: dq <= cmd.part ? ad : an;
          SEL_RED_B: dq <= cmd.part ? bd : bn;
          SEL_LCM:   dq <= cmd.part ? bd : ad;
          default:   dq <= cmd.part ? rd : rn;
        endcase
      end
      CMD_DIV_STEP: begin
        dcnt <= dcnt - 7'd1;
        if (!dtrial[64]) begin
          drem <= dtrial[63:0];
          dq <= {dq[62:0], 1'b1};
        end else begin
          drem <= {drem[62:0], dq[63]};
          dq <= {dq[62:0], 1'b0};
        end
      end
      CMD_APPLY: begin
        case (cmd.sel)
          SEL_RED_A: if (cmd.part) ad <= dq; else an <= dq;
          SEL_RED_B: if (cmd.part) bd <= dq; else bn <= dq;
          SEL_LCM: begin
            // lcm denominator (ad / g) * bd, scale factors kept in ad and bd
            if (cmd.part) begin
              bd <= dq;
            end else begin
              ad <= dq;
              rd <= m_p;
            end
          end
          SEL_SCALE: begin
            if (!cmd.part) begin
              t1 <= m_p;
              s2 <= (bn == 64'd0) ? 1'b0 : ((fn == FUNC_SUB) ? !bn_s : bn_s);
            end else if (an_s == s2) begin
              rn <= t1 + m_p;
              sign_r <= an_s;
            end else if (t1 >= m_p) begin
              rn <= t1 - m_p;
              sign_r <= an_s;
            end else begin
              rn <= m_p - t1;
              sign_r <= s2;
            end
          end
          SEL_MUL: begin
            if (cmd.part) rd <= m_p; else rn <= m_p;
            sign_r <= an_s ^ bn_s;
          end
          SEL_CMP: begin
            if (!cmd.part) t1 <= m_p;
            rn <= 64'd0;
            rd <= 64'd1;
          end
          SEL_RED_R: if (cmd.part) rd <= dq; else rn <= dq;
          default: ;
        endcase
      end
      CMD_FINISH: begin
        status <= err;
        if (err) begin
          res_num <= 64'd0;
          res_den <= 63'd0;
        end else if (fn == FUNC_CMP) begin
          begin
            logic signed [64:0] l, r;
            l = an_s ? -$signed({1'b0, t1}) : $signed({1'b0, t1});
            r = bn_s ? -$signed({1'b0, m_p}) : $signed({1'b0, m_p});
            if (an == 64'd0) l = '0;
            if (bn == 64'd0) r = '0;
            is_greater <= l > r;
            is_less <= l < r;
            is_equal <= l == r;
          end
          res_num <= 64'd0;
          res_den <= 63'd1;
        end else if (fn > 3'(FUNC_CMP)) begin
          res_num <= 64'd0;
          res_den <= 63'd1;
        end else if (rn == 64'd0) begin
          res_num <= 64'd0;
          res_den <= 63'd1;
        end else begin
          res_num <= sign_r ? (64'd0 - rn) : rn;
          res_den <= rd[62:0];
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== src/rfa_control.sv =====
// controller: sequences reduction, scaling and product steps
module rfa_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           func,
  output rfa_pkg::rfa_cmd_t    cmd,
  input  rfa_pkg::rfa_status_t stat
);
  import rfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_GSTART, S_GSTEP, S_DSTART, S_DSTEP, S_APPLY,
    S_MUL0, S_MUL1, S_MULW, S_FIN, S_OUT
  } state_t;

  state_t state, state_next;
  sel_t   sel, sel_next;
  logic   part, part_next;
  logic [2:0] fn;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    sel_next = sel;
    part_next = part;
    cmd.op = CMD_NONE;
    cmd.sel = sel;
    cmd.part = part;
    case (state)
      S_IDLE, S_OUT: begin
        if (state == S_IDLE || out_ready) state_next = S_IDLE;
        if (in_valid && in_ready) begin
          cmd.op = CMD_LOAD;
          state_next = S_GSTART;
          sel_next = SEL_RED_A;
          part_next = 1'b0;
        end
      end
      S_GSTART: begin
        if (stat.op_err) begin
          state_next = S_FIN;
        end else begin
          cmd.op = CMD_GCD_START;
          state_next = S_GSTEP;
        end
      end
      S_GSTEP: begin
        cmd.op = CMD_GCD_STEP;
        if (stat.gcd_done) state_next = S_DSTART;
      end
      S_DSTART: begin
        cmd.op = CMD_DIV_START;
        state_next = S_DSTEP;
      end
      S_DSTEP: begin
        if (stat.div_done) state_next = S_APPLY;
        else cmd.op = CMD_DIV_STEP;
      end
      S_APPLY: begin
        cmd.op = CMD_APPLY;
        if (sel == SEL_LCM && part) begin
          sel_next = SEL_SCALE;
          part_next = 1'b0;
          state_next = S_MUL0;
        end else if (!part) begin
          part_next = 1'b1;
          state_next = S_DSTART;
        end else if (sel == SEL_RED_A) begin
          sel_next = SEL_RED_B;
          part_next = 1'b0;
          state_next = S_GSTART;
        end else if (sel == SEL_RED_B) begin
          part_next = 1'b0;
          if (fn == 3'(FUNC_ADD) || fn == 3'(FUNC_SUB)) begin
            sel_next = SEL_LCM;
            state_next = S_GSTART;
          end else if (fn == 3'(FUNC_MUL) || fn == 3'(FUNC_DIV)) begin
            sel_next = SEL_MUL;
            state_next = S_MUL0;
          end else if (fn == 3'(FUNC_CMP)) begin
            sel_next = SEL_CMP;
            state_next = S_MUL0;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL0: begin
        state_next = S_MULW;
      end
      S_MULW: begin
        cmd.op = CMD_APPLY;
        if (!part) begin
          part_next = 1'b1;
          state_next = S_MUL0;
        end else if (sel == SEL_CMP) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        if (stat.num_zero) begin
          state_next = S_FIN;
        end else begin
          sel_next = SEL_RED_R;
          part_next = 1'b0;
          state_next = S_GSTART;
        end
      end
      S_FIN: begin
        cmd.op = CMD_FINISH;
        state_next = S_OUT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel <= SEL_RED_A;
      part <= 1'b0;
      fn <= 3'd0;
    end else begin
      state <= state_next;
      sel <= sel_next;
      part <= part_next;
      if (cmd.op == CMD_LOAD) fn <= func;
    end
  end
endmodule

// ===== src/rational_fraction_alu_core.sv =====
// Exact fraction alu: a shared binary gcd unit and a 64-step restoring divider
// reduce both operands and, except for a compare, the result, and registered
// 32x32 products serve the scaling and cross-multiplication; an item with a zero
// denominator or a division by zero goes straight to the finish step. One item is
// worked on at a time; the finished result sits in output registers and the next
// item may be taken as it leaves.
module rational_fraction_alu_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] res_num,
  output logic [62:0] res_den,
  output logic        is_greater,
  output logic        is_less,
  output logic        is_equal,
  output logic        status
);
  import rfa_pkg::*;

  rfa_cmd_t    cmd;
  rfa_status_t stat;

  rfa_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .func(func),
    .cmd(cmd), .stat(stat)
  );

  rfa_datapath u_dp (
    .clk(clk), .cmd(cmd), .func(func), .a_num(a_num), .a_den(a_den),
    .b_num(b_num), .b_den(b_den), .stat(stat), .res_num(res_num),
    .res_den(res_den), .is_greater(is_greater), .is_less(is_less),
    .is_equal(is_equal), .status(status)
  );
endmodule

// ===== src/rfa_checker.sv =====
// port-level checker for the fraction alu with its bind
`include "assert_macros.svh"
module rfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] res_num,
  input logic [62:0] res_den,
  input logic        is_greater,
  input logic        is_less,
  input logic        is_equal,
  input logic        status
);
  `ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && status,
    res_den == 63'd0 && res_num == 64'd0, "error result not cleared")
  `ASSERT_IMPLY(a_ok_den, clk, rst, out_valid && !status, res_den != 63'd0,
    "zero denominator without error")
  `ASSERT_IMPLY(a_flags, clk, rst, out_valid,
    $countones({is_greater, is_less, is_equal}) <= 1, "compare flags clash")
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(res_num), "result dropped while stalled")
  `ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !out_valid,
    "result raised right after an item was taken")
endmodule

bind rational_fraction_alu_core rfa_checker u_chk (.*);

// ===== tb/rfa_checker.sv =====
// checker: watches both channels, predicts each fraction result and compares
module rfa_tb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  func,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] res_num,
  input  logic [62:0] res_den,
  input  logic        is_greater,
  input  logic        is_less,
  input  logic        is_equal,
  input  logic        status,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        err;
  } fraction_result_t;

  typedef struct {
    bit          neg;
    logic [63:0] num;
    logic [63:0] den;
  } fraction_t;

  fraction_result_t results_due[$];

  assign pending = results_due.size();

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void simplify(ref fraction_t f);
    logic [63:0] g;
    if (f.num == 0) begin
      f.den = 1;
      f.neg = 0;
      return;
    end
    g = gcd64(f.num, f.den);
    if (g != 0) begin
      f.num = f.num / g;
      f.den = f.den / g;
    end
  endfunction

  function automatic bit load_operand(logic [31:0] n, logic [31:0] d, ref fraction_t f);
    f.num = n[31] ? {32'd0, -n} : {32'd0, n};
    f.den = d[31] ? {32'd0, -d} : {32'd0, d};
    f.neg = n[31] != d[31];
    if (f.den == 0) return 0;
    simplify(f);
    return 1;
  endfunction

  function automatic fraction_result_t compute_fraction(logic [2:0] op, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    fraction_t a, b, r;
    fraction_result_t e;
    bit ok_a, ok_b, err, s2;
    logic [63:0] g, fa, fb, t1, t2;
    logic signed [63:0] l, rr;
    ok_a = load_operand(an, ad, a);
    ok_b = load_operand(bn, bd, b);
    err = 0;
    e = '0;
    r.neg = 0;
    r.num = 0;
    r.den = 1;
    if (!ok_a || !ok_b) begin
      err = 1;
    end else if (op == FUNC_ADD || op == FUNC_SUB) begin
      g = gcd64(a.den, b.den);
      fa = b.den / g;
      fb = a.den / g;
      t1 = a.num * fa;
      t2 = b.num * fb;
      s2 = (op == FUNC_SUB) ? !b.neg : b.neg;
      if (b.num == 0) s2 = 0;
      if (a.neg == s2) begin
        r.num = t1 + t2;
        r.neg = a.neg;
      end else if (t1 >= t2) begin
        r.num = t1 - t2;
        r.neg = a.neg;
      end else begin
        r.num = t2 - t1;
        r.neg = s2;
      end
      r.den = fb * b.den;
      simplify(r);
    end else if (op == FUNC_MUL) begin
      r.num = a.num * b.num;
      r.den = a.den * b.den;
      r.neg = a.neg != b.neg;
      simplify(r);
    end else if (op == FUNC_DIV) begin
      if (b.num == 0) begin
        err = 1;
      end else begin
        r.num = a.num * b.den;
        r.den = a.den * b.num;
        r.neg = a.neg != b.neg;
        simplify(r);
      end
    end else if (op == FUNC_CMP) begin
      l = a.num * b.den;
      rr = b.num * a.den;
      if (a.neg) l = -l;
      if (b.neg) rr = -rr;
      e.gt = l > rr;
      e.lt = l < rr;
      e.eq = l == rr;
    end
    if (!err && (r.num[63] || r.den[63] || r.den == 0)) err = 1;
    if (err) begin
      e = '0;
      e.err = 1;
    end else begin
      e.num = r.neg ? -r.num : r.num;
      e.den = r.den[62:0];
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    fraction_result_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        results_due.push_back(compute_fraction(func, a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected item", res_num, 64'd0);
        end else begin
          e = results_due.pop_front();
          if (res_num !== e.num) report_mismatch("res_num", res_num, e.num);
          if (res_den !== e.den) report_mismatch("res_den", 64'(res_den), 64'(e.den));
          if (is_greater !== e.gt)
            report_mismatch("is_greater", 64'(is_greater), 64'(e.gt));
          if (is_less !== e.lt) report_mismatch("is_less", 64'(is_less), 64'(e.lt));
          if (is_equal !== e.eq) report_mismatch("is_equal", 64'(is_equal), 64'(e.eq));
          if (status !== e.err) report_mismatch("status", 64'(status), 64'(e.err));
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// testbench top: drives fraction items with gaps, stalls the result side, gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  func;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] res_num;
  logic [62:0] res_den;
  logic        is_greater;
  logic        is_less;
  logic        is_equal;
  logic        status;
  int          fail_count;
  int          pending;
  bit          hold_off;

  rational_fraction_alu_core u_dut (.*);

  rfa_tb_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] pick_value(bit den_side);
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000001;
      2: return den_side ? 32'd1 : 32'd0;
      3: return $urandom_range(0, 1) ? 32'd1 : 32'hffffffff;
      4: return $urandom;
      5: return $urandom_range(0, 4) == 0 ? 32'd0 : $urandom_range(1, 60);
      6: return -$urandom_range(1, 60);
      7: return $urandom_range(0, 1) ? $urandom_range(1, 1 << 16) : -$urandom_range(1, 1 << 16);
      8: return 32'h80000000 | $urandom;
      default: return $urandom_range(1, 1000) * 12;
    endcase
  endfunction

  task automatic send_item(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    in_valid <= 1;
    func <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic random_item();
    logic [31:0] d1, d2;
    d1 = pick_value(1);
    d2 = pick_value(1);
    if (d1 == 0 && $urandom_range(0, 3) != 0) d1 = 1;
    if (d2 == 0 && $urandom_range(0, 3) != 0) d2 = 7;
    send_item($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
              pick_value(0), d1, pick_value(0), d2);
  endtask

  initial begin
    int gaps;
    rst = 1;
    in_valid = 0;
    func = FUNC_ADD;
    a_num = 0;
    a_den = 1;
    b_num = 0;
    b_den = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_item(FUNC_ADD, 32'h7fffffff, 32'h7fffffff, 32'h80000001, 32'd1);
    send_item(FUNC_ADD, 32'h7fffffff, 32'h7ffffffe, 32'h7fffffff, 32'h7ffffffd);
    send_item(FUNC_SUB, 32'h80000001, 32'h7ffffffe, 32'h7fffffff, 32'h7ffffffd);
    send_item(FUNC_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
    send_item(FUNC_SUB, 32'd5, 32'd6, 32'd0, 32'hfffffff9);
    send_item(FUNC_MUL, 32'h80000001, 32'd1, 32'h80000001, 32'd1);
    send_item(FUNC_MUL, 32'd1, 32'h7fffffff, 32'd1, 32'h80000001);
    send_item(FUNC_MUL, 32'd0, 32'hffffffff, 32'd5, 32'd3);
    send_item(FUNC_DIV, 32'd6, 32'hfffffff8, 32'd9, 32'd4);
    send_item(FUNC_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
    send_item(FUNC_DIV, 32'h7fffffff, 32'd1, 32'd1, 32'h7fffffff);
    send_item(FUNC_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
    send_item(FUNC_CMP, 32'hffffffff, 32'd3, 32'd1, 32'd3);
    send_item(FUNC_CMP, 32'h7fffffff, 32'd1, 32'h80000001, 32'd1);
    send_item(FUNC_CMP, 32'd0, 32'd5, 32'd0, 32'hfffffffd);
    send_item(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(FUNC_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
    send_item(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);
    send_item(3'd7, 32'hffffffff, 32'h80000000, 32'h80000000, 32'hffffffff);
    send_item(FUNC_ADD, 32'h80000000, 32'h80000000, 32'hffffffff, 32'h80000000);
    send_item(FUNC_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000001);
    for (int i = 0; i < 1430; ) begin
      gaps = $urandom_range(1, 12);
      for (int k = 0; k < gaps && i < 1430; k++, i++) random_item();
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 300)) @(negedge clk);
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // result side stalls, with one long hold-off
  initial begin
    int run;
    out_ready = 0;
    hold_off = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run = $urandom_range(0, 3);
      if (!hold_off && $urandom_range(0, 60) == 0) begin
        hold_off = 1;
        out_ready <= 0;
        repeat (5000) @(negedge clk);
      end else if (run == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 400)) @(negedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 500)) @(negedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
